// ===== rtl/fdbu_pkg.sv =====
package fdbu_pkg;

    // Table geometry
    localparam int BASE_ENTRIES = 10;
    localparam int ADDR_W       = (BASE_ENTRIES > 1) ? $clog2(BASE_ENTRIES) : 1;
    localparam int IDX_W        = 4;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Status words
    localparam logic [15:0] ST_DOWN  = 16'h0002;
    localparam logic [15:0] ST_UP    = 16'h0200;
    localparam logic [15:0] ST_REV_A = 16'h0080;
    localparam logic [15:0] ST_REV_B = 16'h0082;

    // Word building constants
    localparam logic [15:0] UP_DEFAULT_OFFSET = 16'h0015;
    localparam logic [15:0] UP_NOTOUCH_WORD   = 16'h1380;
    localparam logic [7:0]  LOW_MARK          = 8'h80;
    localparam logic [7:0]  NOTOUCH_SUB       = 8'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALT_ROUNDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_2ND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAC_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MODE  = 3'd4;

    // Wait modes
    localparam logic [1:0] WAIT_IDLE = 2'd0;
    localparam logic [1:0] WAIT_DOWN = 2'd1;
    localparam logic [1:0] WAIT_UP   = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2,
        EV_REV  = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        FG_UNKNOWN = 2'd0,
        FG_DOWN    = 2'd1,
        FG_UP      = 2'd2
    } t_finger;

    // Decoded request handed to the table stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             write;
        logic             use_min;
        logic [15:0]      word;
        t_event           event_code;
        t_finger          finger;
        logic             resend;
        logic             last;
    } t_req;

    // Finished result
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             written;
        logic [15:0]      word;
        t_event           event_code;
        t_finger          finger;
        logic             resend;
        logic             last;
    } t_res;

    // Down-base word: half of the raw value in the high byte
    function automatic logic [15:0] down_word(input logic [15:0] raw);
        return {raw[8:1], LOW_MARK};
    endfunction

    // Up-base word before the keep-minimum limit
    function automatic logic [15:0] up_word(input logic [15:0] raw,
                                            input logic [15:0] dac,
                                            input logic        touched,
                                            input logic        second);
        logic [7:0] off_lo;
        logic [7:0] hi;
        off_lo = (dac == 16'd0) ? UP_DEFAULT_OFFSET[7:0] : dac[7:0];
        hi     = raw[8:1] + off_lo;
        if (!second && !touched) begin
            if (dac == 16'd0) begin
                return UP_NOTOUCH_WORD;
            end
            return {dac[7:0] - NOTOUCH_SUB, LOW_MARK};
        end
        return {hi, LOW_MARK};
    endfunction

endpackage

// ===== rtl/finger_detect_base_update.sv =====
// Finger-detect base table update. One base entry per request; a new request is taken
// every cycle while the output register is free or being drained, so throughput is one
// entry per clock. The stage register holds a request and its read of the ten-word base
// table (synchronous memory, one read and one write port); it applies the keep-minimum
// limit and writes the word back as it retires into the output register, forwarding
// when consecutive entries hit the same word. Per-entry valid bits make the table read
// as zero after reset, so no clearing pass is needed. Configuration is written through
// the plain write port; the user must do so only while the block is idle; not enforced.
module finger_detect_base_update
    import fdbu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [47:0]          i_s_axis_tdata,  // frame_status, touch_flags, entry_raw
    input  logic                 i_s_axis_tuser,  // entry_valid
    input  logic                 i_s_axis_tlast,  // last_entry
    // output stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [31:0]          o_m_axis_tdata,  // entry_index, table_word, event_code,
                                                  // finger_state, resend_down
    output logic                 o_m_axis_tuser,  // word_written
    output logic                 o_m_axis_tlast   // frame_done
);

    t_req req;
    t_res s1_res;
    t_res r_out;
    logic r_out_vld;
    logic s1_vld;
    logic acc;
    logic adv;

    // Handshake: stage retires into a free or draining output register
    assign adv             = s1_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !s1_vld || adv;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    fdbu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_status    (i_s_axis_tdata[15:0]),
        .i_touch     (i_s_axis_tdata[25:16]),
        .i_raw       (i_s_axis_tdata[41:26]),
        .i_valid     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .o_req       (req)
    );

    fdbu_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_req    (req),
        .i_adv    (adv),
        .o_s1_vld (s1_vld),
        .o_res    (s1_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= s1_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {7'd0, r_out.resend, r_out.finger, r_out.event_code,
                              r_out.word, r_out.idx};
    assign o_m_axis_tuser  = r_out.written;
    assign o_m_axis_tlast  = r_out.last;

endmodule

// ===== rtl/fdbu_decode.sv =====
module fdbu_decode
    import fdbu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_acc,
    input  logic [15:0]          i_status,
    input  logic [9:0]           i_touch,
    input  logic [15:0]          i_raw,
    input  logic                 i_valid,
    input  logic                 i_last,
    output t_req                 o_req
);

    logic        r_alt;
    logic        r_fixed;
    logic        r_keep_min;
    logic [15:0] r_dac;
    logic [1:0]  r_wait;

    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_toggle, n_toggle;
    t_finger          r_finger, n_finger;

    t_event     ev;
    logic       in_range;
    logic       touched;
    logic       second;
    logic [15:0] touch_ext;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt      <= 1'b0;
            r_fixed    <= 1'b0;
            r_keep_min <= 1'b0;
            r_dac      <= '0;
            r_wait     <= WAIT_IDLE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ALT_ROUNDS: r_alt      <= i_cfg_wdata[0];
                CFG_FIXED_2ND:  r_fixed    <= i_cfg_wdata[0];
                CFG_KEEP_MIN:   r_keep_min <= i_cfg_wdata[0];
                CFG_DAC_OFFSET: r_dac      <= i_cfg_wdata;
                CFG_WAIT_MODE:  r_wait     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Status decode
    always_comb begin
        case (i_status)
            ST_DOWN:            ev = EV_DOWN;
            ST_UP:              ev = EV_UP;
            ST_REV_A, ST_REV_B: ev = EV_REV;
            default:            ev = EV_NONE;
        endcase
    end

    // Per-entry decisions; touch bits above bit 9 read as zero
    assign touch_ext = {6'd0, i_touch};
    assign touched   = touch_ext[r_cnt];
    assign in_range  = ({1'b0, r_cnt} < (IDX_W + 1)'(BASE_ENTRIES));
    always_comb begin
        second = r_fixed;
        if (r_alt) begin
            second = (r_cnt == '0) ? r_toggle : ~r_toggle;
        end
    end

    // Next state of counter, round toggle and finger
    always_comb begin
        n_cnt    = r_cnt;
        n_toggle = r_toggle;
        n_finger = r_finger;
        if (i_valid) begin
            if (r_cnt != IDX_MAX) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (ev == EV_DOWN && r_alt && r_cnt == '0) begin
                n_toggle = ~r_toggle;
            end
        end
        if (i_last) begin
            n_cnt = '0;
        end
        if (ev == EV_DOWN) begin
            n_finger = FG_DOWN;
        end else if (ev == EV_UP) begin
            n_finger = FG_UP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_toggle <= 1'b0;
            r_finger <= FG_UNKNOWN;
        end else if (i_acc) begin
            r_cnt    <= n_cnt;
            r_toggle <= n_toggle;
            r_finger <= n_finger;
        end
    end

    // Request for the table stage
    always_comb begin
        o_req.idx        = r_cnt;
        o_req.write      = i_valid && (ev != EV_NONE) && in_range;
        o_req.use_min    = r_keep_min && (ev == EV_DOWN);
        o_req.word       = (ev == EV_DOWN) ? up_word(i_raw, r_dac, touched, second)
                                           : down_word(i_raw);
        o_req.event_code = ev;
        o_req.finger     = n_finger;
        o_req.resend     = (ev == EV_REV) && (r_wait == WAIT_DOWN);
        o_req.last       = i_last;
    end

endmodule

// ===== rtl/fdbu_table.sv =====
module fdbu_table
    import fdbu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_req i_req,
    input  logic i_adv,
    output logic o_s1_vld,
    output t_res o_res
);

    logic [15:0]             r_mem [BASE_ENTRIES];
    logic [BASE_ENTRIES-1:0] r_ent_vld;

    logic        r_s1_vld;
    t_req        r_s1;
    logic [15:0] r_rd_data;
    logic        r_rd_vld;
    logic        r_fwd;
    logic [15:0] r_fwd_word;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       prev;
    logic [15:0]       fin_word;
    logic              wr_en;

    assign rd_addr = i_req.idx[ADDR_W-1:0];
    assign wr_addr = r_s1.idx[ADDR_W-1:0];
    assign wr_en   = i_adv && r_s1.write;

    // Stored word; unwritten entries read as zero, same-entry write forwarded
    assign prev     = r_fwd ? r_fwd_word : (r_rd_vld ? r_rd_data : 16'd0);
    assign fin_word = (r_s1.use_min && r_s1.word > prev) ? prev : r_s1.word;

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_acc) begin
                r_s1_vld <= 1'b1;
                r_fwd    <= wr_en && (r_s1.idx == i_req.idx);
            end else if (i_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1       <= i_req;
            r_fwd_word <= fin_word;
        end
    end

    // Table memory, read at request, written when the stage retires
    always_ff @(posedge i_clk) begin
        if (i_acc && i_req.write) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= fin_word;
        end
    end

    // Entry valid bits stand in for the cleared table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_acc && i_req.write) begin
                r_rd_vld <= r_ent_vld[rd_addr];
            end
            if (wr_en) begin
                r_ent_vld[wr_addr] <= 1'b1;
            end
        end
    end

    assign o_s1_vld = r_s1_vld;

    always_comb begin
        o_res.idx        = r_s1.idx;
        o_res.written    = r_s1.write;
        o_res.word       = r_s1.write ? fin_word : 16'd0;
        o_res.event_code = r_s1.event_code;
        o_res.finger     = r_s1.finger;
        o_res.resend     = r_s1.resend;
        o_res.last       = r_s1.last;
    end

endmodule
